>>> rtl/s64dec_pkg.sv
// Shared types, constants and helper functions for the signed 64-bit to decimal ASCII unit.
// Used by the top level, its port checker and the testbench checker. Has no dependencies.

package s64dec_pkg;

	// Width of the input value and number of BCD digits kept for its magnitude.
	localparam int unsigned MAG_W          = 64;
	localparam int unsigned NUM_DIGITS     = 20;
	localparam int unsigned BCD_W          = 4 * NUM_DIGITS;
	localparam int unsigned BITS_PER_CYCLE = 2;
	localparam int unsigned CONV_STEPS     = MAG_W / BITS_PER_CYCLE;

	// Character codes and register reset value.
	localparam logic [7:0] ASCII_ZERO      = 8'h30;
	localparam logic [7:0] ASCII_NINE      = 8'h39;
	localparam logic [7:0] ASCII_MINUS     = 8'h2D;
	localparam logic [7:0] ASCII_NUL       = 8'h00;
	localparam logic [7:0] BUF_SIZE_RESET  = 8'd255;

	// Result status codes.
	localparam logic STATUS_OK        = 1'b0;
	localparam logic STATUS_TOO_SMALL = 1'b1;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_CHECK,
		ST_ERR,
		ST_SIGN,
		ST_DIGIT,
		ST_TERM
	} s64dec_state_t;

	// One shift-add-3 step: correct every BCD digit of five or more, then shift in one bit.
	function automatic logic [BCD_W-1:0] dabble_step(input logic [BCD_W-1:0] bcd,
	                                                 input logic in_bit);
		logic [BCD_W-1:0] adj;
		adj = bcd;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (adj[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = adj[4*i +: 4] + 4'd3;
			end
		end
		return {adj[BCD_W-2:0], in_bit};
	endfunction

endpackage

>>> rtl/signed_int64_to_decimal_ascii_unit.sv
// Signed 64-bit integer to decimal ASCII converter, one character per output transfer.
// Depends on s64dec_pkg for constants, the state type and the shift-add-3 step.
//
//  Channel   Signals                         Contents
//  input     s_tvalid s_tready s_tdata[63:0] value (signed, two's complement)
//  output    m_tvalid m_tready m_tdata[7:0]  character; m_tlast = last; m_tuser = status
//  config    cfg_we cfg_wdata[7:0]           buffer_size, written while cfg_we is high
//
// A value is accepted, converted in the shift-add-3 unit (two bits per cycle), then the
// leading zero digits are skipped (one per cycle), the length is checked, and one output
// character (1 to 21 per value) is sent per cycle while the output register is free; the
// next value is accepted only after the last character of the previous one is loaded.
// s_tready is high only while the sequencer is idle; output stalls hold the sequencer.
// Reset clears the sequencer, the output valid and sets buffer_size to 255.

module signed_int64_to_decimal_ascii_unit
	import s64dec_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Input stream, s_tdata: [63:0] value.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,
	// Output stream, m_tdata: [7:0] character; m_tuser: [0] status.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,
	output logic        m_tlast,
	output logic        m_tuser,
	// Configuration write port for buffer_size.
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata
);

	s64dec_state_t    state_q, state_d;
	logic [MAG_W-1:0] mag_q;
	logic [BCD_W-1:0] bcd_q;
	logic             neg_q;
	logic [4:0]       cnt_q;
	logic [4:0]       idx_q;
	logic [7:0]       buf_size_q;
	logic             m_tvalid_q;
	logic [7:0]       m_char_q;
	logic             m_last_q;
	logic             m_status_q;

	logic             accept;
	logic             out_free;
	logic             load_out;
	logic [7:0]       out_char;
	logic             out_last;
	logic             out_status;
	logic             idx_dec;
	logic [3:0]       cur_digit;
	logic [7:0]       needed;
	logic [BCD_W-1:0] bcd_next;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// Digit under the pointer and the text length including sign and terminator.
	assign cur_digit = bcd_q[{idx_q, 2'b00} +: 4];
	assign needed    = {7'd0, neg_q} + {3'd0, idx_q} + 8'd2;

	// Two shift-add-3 steps per cycle, most significant magnitude bits first.
	assign bcd_next = dabble_step(dabble_step(bcd_q, mag_q[MAG_W-1]), mag_q[MAG_W-2]);

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and output register load.
	always_comb begin
		state_d    = state_q;
		load_out   = 1'b0;
		out_char   = ASCII_NUL;
		out_last   = 1'b0;
		out_status = STATUS_OK;
		idx_dec    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_CONV;
				end
			end
			ST_CONV: begin
				if (cnt_q == 5'(CONV_STEPS - 1)) begin
					state_d = ST_SKIP;
				end
			end
			ST_SKIP: begin
				if (idx_q != 5'd0 && cur_digit == 4'd0) begin
					idx_dec = 1'b1;
				end else begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (needed > buf_size_q) begin
					state_d = ST_ERR;
				end else if (neg_q) begin
					state_d = ST_SIGN;
				end else begin
					state_d = ST_DIGIT;
				end
			end
			ST_ERR: begin
				if (out_free) begin
					load_out   = 1'b1;
					out_last   = 1'b1;
					out_status = STATUS_TOO_SMALL;
					state_d    = ST_IDLE;
				end
			end
			ST_SIGN: begin
				if (out_free) begin
					load_out = 1'b1;
					out_char = ASCII_MINUS;
					state_d  = ST_DIGIT;
				end
			end
			ST_DIGIT: begin
				if (out_free) begin
					load_out = 1'b1;
					out_char = ASCII_ZERO + {4'd0, cur_digit};
					if (idx_q == 5'd0) begin
						state_d = ST_TERM;
					end else begin
						idx_dec = 1'b1;
					end
				end
			end
			ST_TERM: begin
				if (out_free) begin
					load_out = 1'b1;
					out_last = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Magnitude, BCD accumulator, step counter and digit pointer.
	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q <= s_tdata[MAG_W-1];
			mag_q <= s_tdata[MAG_W-1] ? (~s_tdata + 64'd1) : s_tdata;
			bcd_q <= '0;
			cnt_q <= '0;
			idx_q <= 5'(NUM_DIGITS - 1);
		end else if (state_q == ST_CONV) begin
			bcd_q <= bcd_next;
			mag_q <= {mag_q[MAG_W-3:0], 2'b00};
			cnt_q <= cnt_q + 5'd1;
		end else if (idx_dec) begin
			idx_q <= idx_q - 5'd1;
		end
	end

	// Buffer size register; the host must write it only while no value is in flight (not enforced).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_size_q <= BUF_SIZE_RESET;
		end else if (cfg_we) begin
			buf_size_q <= cfg_wdata;
		end
	end

	// Output register: holds a result until the downstream transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_char_q   <= out_char;
			m_last_q   <= out_last;
			m_status_q <= out_status;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_char_q;
	assign m_tlast  = m_last_q;
	assign m_tuser  = m_status_q;

endmodule

>>> rtl/s64dec_checker.sv
// Port-level checker for the signed 64-bit to decimal ASCII unit, bound to the top level.
// Depends on s64dec_pkg for character and status codes.

module s64dec_checker
	import s64dec_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic        m_tlast,
	input logic        m_tuser
);

	// A stalled result keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("output result changed while stalled");

	// After an input transfer the unit is busy converting.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted again right after a transfer");

	// An error result is a single terminating NUL.
	a_err_form: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == STATUS_TOO_SMALL |-> m_tlast && m_tdata == ASCII_NUL)
		else $error("malformed error result");

	// A final ok result is the terminator; others are a sign or a digit.
	a_char_form: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == STATUS_OK |->
			(m_tlast && m_tdata == ASCII_NUL) ||
			(!m_tlast && (m_tdata == ASCII_MINUS ||
				(m_tdata >= ASCII_ZERO && m_tdata <= ASCII_NINE))))
		else $error("unexpected character in output text");

endmodule

bind signed_int64_to_decimal_ascii_unit s64dec_checker u_s64dec_checker (.*);

>>> tb/decimal_text_checker.sv
// Checker for the signed 64-bit to decimal ASCII unit: watches the input, output and
// configuration channels, predicts the character stream and compares every output transfer.
// Depends on s64dec_pkg for the character codes, status codes and reset value.

module decimal_text_checker
	import s64dec_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [63:0]       s_tdata,
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [7:0]        m_tdata,
	input  logic              m_tlast,
	input  logic              m_tuser,
	input  logic              cfg_we,
	input  logic [7:0]        cfg_wdata,
	output int unsigned       fail_count,
	output int unsigned       chars_pending
);

	// One predicted output character with its framing and status.
	typedef struct packed {
		logic [7:0] character;
		logic       last;
		logic       status;
	} text_char_t;

	text_char_t  text_queue[$];
	logic [7:0]  buf_size;
	int unsigned errors;

	// Build the expected characters for one value and queue them.
	task automatic predict_text(input logic [63:0] value);
		logic        neg;
		logic [63:0] mag;
		logic [3:0]  digits [NUM_DIGITS];
		int unsigned count;
		int unsigned needed;
		int          i;
		neg = value[63];
		mag = neg ? (64'd0 - value) : value;
		count = 0;
		do begin
			digits[count] = 4'(mag % 64'd10);
			count++;
			mag = mag / 64'd10;
		end while (mag != 64'd0);
		needed = int'(neg) + count + 1;
		if (needed > buf_size) begin
			text_queue.push_back('{ASCII_NUL, 1'b1, STATUS_TOO_SMALL});
		end else begin
			if (neg) begin
				text_queue.push_back('{ASCII_MINUS, 1'b0, STATUS_OK});
			end
			for (i = int'(count) - 1; i >= 0; i--) begin
				text_queue.push_back('{ASCII_ZERO + 8'(digits[i]), 1'b0, STATUS_OK});
			end
			text_queue.push_back('{ASCII_NUL, 1'b1, STATUS_OK});
		end
	endtask

	// Track the buffer size, check output transfers, then predict from input transfers.
	// The output is checked first so that a character leaving on the same edge as a new
	// value arrives is matched against the older conversion.
	always @(posedge clk or negedge arst_n) begin
		text_char_t want;
		if (!arst_n) begin
			buf_size <= BUF_SIZE_RESET;
			text_queue.delete();
			errors = 0;
			fail_count <= 0;
			chars_pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (text_queue.size() == 0) begin
					errors++;
					if (errors <= 10) begin
						$display("output transfer with nothing expected: char %h last %b status %b",
							m_tdata, m_tlast, m_tuser);
					end
				end else begin
					want = text_queue.pop_front();
					if (m_tdata !== want.character || m_tlast !== want.last ||
							m_tuser !== want.status) begin
						errors++;
						if (errors <= 10) begin
							$display("mismatch: expected char %h last %b status %b, got char %h last %b status %b",
								want.character, want.last, want.status, m_tdata, m_tlast, m_tuser);
						end
					end
				end
			end
			if (s_tvalid && s_tready) begin
				predict_text(s_tdata);
			end
			if (cfg_we) begin
				buf_size <= cfg_wdata;
			end
			fail_count <= errors;
			chars_pending <= text_queue.size();
		end
	end

endmodule

>>> tb/signed_int64_to_decimal_ascii_unit_tb.sv
// Top of the testbench for the signed 64-bit to decimal ASCII unit: clock, reset, stimulus,
// random back-pressure and the verdict. Depends on the unit and decimal_text_checker.

module signed_int64_to_decimal_ascii_unit_tb;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;   // [63:0] value
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // [7:0] character
	logic        m_tlast;
	logic        m_tuser;   // [0] status
	logic        cfg_we;
	logic [7:0]  cfg_wdata;

	int unsigned fail_count;
	int unsigned chars_pending;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;

	localparam logic [63:0] INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] INT64_MIN = 64'h8000_0000_0000_0000;

	signed_int64_to_decimal_ascii_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	decimal_text_checker checker_inst (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tlast       (m_tlast),
		.m_tuser       (m_tuser),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.fail_count    (fail_count),
		.chars_pending (chars_pending)
	);

	// Free-running clock with a period of four.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Receiver back-pressure, redrawn every cycle.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Offer one value, with a random gap first, and hold it until the transfer.
	task automatic send_value(input logic [63:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
	endtask

	// Stop offering input and wait until every predicted character has been seen.
	task automatic drain(input int unsigned tail);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (chars_pending != 0) begin
			@(posedge clk);
		end
		repeat (tail) @(posedge clk);
	endtask

	// Single-cycle write of the buffer size.
	task automatic write_buf_size(input logic [7:0] size);
		cfg_we    <= 1'b1;
		cfg_wdata <= size;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Mostly roomy buffers, with regular visits to the small sizes where errors occur.
	function automatic logic [7:0] pick_buf_size();
		case ($urandom_range(3))
			0:       return 8'($urandom_range(21));
			1:       return 8'd255;
			default: return 8'($urandom_range(255, 18));
		endcase
	endfunction

	// Values of every length: extremes, full-width noise and shortened magnitudes.
	function automatic logic [63:0] pick_value();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(4))
					0:       return INT64_MIN;
					1:       return INT64_MAX;
					2:       return 64'd0;
					3:       return '1;
					default: return INT64_MIN + 64'd1;
				endcase
			end
			1, 2, 3: return r;
			default: begin
				r = r >> $urandom_range(63, 1);
				return $urandom_range(1) ? (64'd0 - r) : r;
			end
		endcase
	endfunction

	// Reset, directed cases, then random groups under three back-pressure settings.
	initial begin
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		arst_n        = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Roomy buffer: zero, digit boundaries, both extremes and bit patterns.
		write_buf_size(8'd255);
		send_value(64'd0);
		send_value(64'd1);
		send_value('1);
		send_value(64'd9);
		send_value(64'd10);
		send_value(64'd0 - 64'd10);
		send_value(INT64_MAX);
		send_value(INT64_MIN);
		send_value(INT64_MIN + 64'd1);
		send_value(64'd999_999_999_999_999_999);
		send_value(64'd1_000_000_000_000_000_000);
		send_value(64'd0 - 64'd1_000_000_000_000_000_000);
		send_value(64'h5555_5555_5555_5555);
		send_value(64'hAAAA_AAAA_AAAA_AAAA);
		drain(8);

		// No buffer at all: every value is an error.
		write_buf_size(8'd0);
		send_value(64'd0);
		send_value(INT64_MIN);
		drain(8);

		// Buffer of two: one digit fits, a sign or a second digit does not.
		write_buf_size(8'd2);
		send_value(64'd0);
		send_value(64'd9);
		send_value(64'd10);
		send_value('1);
		drain(8);

		// Exact fit and one short for the longest texts.
		write_buf_size(8'd21);
		send_value(INT64_MIN);
		send_value(INT64_MAX);
		drain(8);
		write_buf_size(8'd20);
		send_value(INT64_MIN);
		send_value(INT64_MAX);
		drain(8);

		// Random groups: each idling setting gets three buffer sizes.
		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin
					send_idle_pct = 38;
					recv_idle_pct = 57;
				end
				1: begin
					send_idle_pct = 57;
					recv_idle_pct = 38;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int grp = 0; grp < 3; grp++) begin
				write_buf_size(pick_buf_size());
				repeat (17) send_value(pick_value());
				drain(8);
			end
		end

		drain(80);
		if (fail_count == 0 && chars_pending == 0) begin
			$display("signed_int64_to_decimal_ascii_unit_tb: clean");
		end else begin
			$display("signed_int64_to_decimal_ascii_unit_tb: errors");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#2000000;
		$display("signed_int64_to_decimal_ascii_unit_tb: errors");
		$finish;
	end

endmodule

>>> sim.f
rtl/s64dec_pkg.sv
rtl/signed_int64_to_decimal_ascii_unit.sv
rtl/s64dec_checker.sv
tb/decimal_text_checker.sv
tb/signed_int64_to_decimal_ascii_unit_tb.sv
